### sv/sstf_pkg.sv
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared types and constants of the shortest-seek-first scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

    localparam int unsigned CYL_PORT_W = 16;
    localparam int unsigned TOTAL_W    = 22;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_PICK,
        ST_EMIT
    } sstf_state_t;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_step;
        logic commit;
        logic finish;
    } sstf_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic seq_end;
    } sstf_status_t;

endpackage

### sv/shortest_seek_first_scheduler_unit.sv
// ----------------------------------------------------------------------------
// shortest_seek_first_scheduler_unit
// Shortest-seek-first disk request scheduler, top level.
// ----------------------------------------------------------------------------
// Requests load one beat per cycle into a request RAM with one write and one
// read port; the first beat of a batch also sets the start head. The beat
// marked batch_end closes the batch. Each result then takes a scan that reads
// every stored request through the one RAM read port, the last compare, a
// commit of the pick and the delivery of the beat, which waits out any output
// stall. No new request is taken until the last result of the batch leaves.
// Requests beyond MAX_REQUESTS are dropped and flag overflow on every result.
// ----------------------------------------------------------------------------
module shortest_seek_first_scheduler_unit
    import sstf_pkg::*;
#(
    parameter int unsigned MAX_REQUESTS = 64,
    parameter int unsigned CYL_BITS     = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CYL_PORT_W-1:0] cylinder,
    input  logic [CYL_PORT_W-1:0] start_head,
    input  logic                  batch_end,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CYL_PORT_W-1:0] served_cylinder,
    output logic [CYL_PORT_W-1:0] seek_distance,
    output logic [TOTAL_W-1:0]    total_seek,
    output logic                  overflow,
    output logic                  sequence_end
);

    sstf_cmd_t    cmd;
    sstf_status_t status;

    sstf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .batch_end (batch_end),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    sstf_dp #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .CYL_BITS     (CYL_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cylinder        (cylinder),
        .start_head      (start_head),
        .served_cylinder (served_cylinder),
        .seek_distance   (seek_distance),
        .total_seek      (total_seek),
        .overflow        (overflow),
        .sequence_end    (sequence_end)
    );

    a_busy_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && batch_end |=> in_stall)
        else $error("input taken after batch end");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall))
        else $error("result pending while loading");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && sequence_end |=> !out_valid && !in_stall)
        else $error("no return to loading after last result");

    a_first_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && batch_end |=> !out_valid)
        else $error("result delivered without a scan");

endmodule

### sv/sstf_ram.sv
// ----------------------------------------------------------------------------
// sstf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sstf_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/sstf_ctrl.sv
// ----------------------------------------------------------------------------
// sstf_ctrl
// Controller: load requests, then scan, pick and deliver one result per pass.
// ----------------------------------------------------------------------------
module sstf_ctrl
    import sstf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         batch_end,
    input  logic         out_stall,
    input  sstf_status_t status,
    output sstf_cmd_t    cmd,
    output logic         in_stall,
    output logic         out_valid
);

    sstf_state_t state_reg;
    sstf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (batch_end)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                cmd.commit = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (status.seq_end)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

### sv/sstf_dp.sv
// ----------------------------------------------------------------------------
// sstf_dp
// Datapath: request store, served mask, nearest-request search and totals.
// ----------------------------------------------------------------------------
module sstf_dp
    import sstf_pkg::*;
#(
    parameter int unsigned MAX_REQUESTS = 64,
    parameter int unsigned CYL_BITS     = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sstf_cmd_t             cmd,
    output sstf_status_t          status,
    input  logic [CYL_PORT_W-1:0] cylinder,
    input  logic [CYL_PORT_W-1:0] start_head,
    output logic [CYL_PORT_W-1:0] served_cylinder,
    output logic [CYL_PORT_W-1:0] seek_distance,
    output logic [TOTAL_W-1:0]    total_seek,
    output logic                  overflow,
    output logic                  sequence_end
);

    localparam int unsigned IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int unsigned SUM_W = ((CYL_BITS > TOTAL_W) ? CYL_BITS : TOTAL_W) + 1;

    logic [CNT_W-1:0]        count_reg,    count_next;
    logic [CNT_W-1:0]        emitted_reg,  emitted_next;
    logic [CYL_BITS-1:0]     head_reg,     head_next;
    logic [TOTAL_W-1:0]      total_reg,    total_next;
    logic                    drop_reg,     drop_next;
    logic [MAX_REQUESTS-1:0] served_reg,   served_next;
    logic [IDX_W-1:0]        addr_reg,     addr_next;
    logic                    issue_reg,    issue_next;
    logic                    pend_reg,     pend_next;
    logic                    last_reg,     last_next;
    logic [IDX_W-1:0]        rd_idx_reg,   rd_idx_next;
    logic                    found_reg,    found_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic [CYL_BITS-1:0]     best_cyl_reg, best_cyl_next;
    logic [CYL_BITS-1:0]     best_d_reg,   best_d_next;
    logic [CYL_PORT_W-1:0]   seek_reg,     seek_next;
    logic                    seq_end_reg,  seq_end_next;

    logic                    full;
    logic                    ram_we;
    logic [CYL_BITS-1:0]     rdata;
    logic [CYL_BITS-1:0]     seek_gap;
    logic [SUM_W-1:0]        sum;
    logic                    addr_last;

    assign full      = (count_reg == CNT_W'(MAX_REQUESTS));
    assign ram_we    = cmd.load && !full;
    assign addr_last = (({1'b0, CNT_W'(addr_reg)} + 1'b1) == {1'b0, count_reg});
    assign seek_gap  = (rdata > head_reg) ? (rdata - head_reg) : (head_reg - rdata);
    assign sum       = SUM_W'(total_reg) + SUM_W'(best_d_reg);

    sstf_ram #(
        .WIDTH (CYL_BITS),
        .DEPTH (MAX_REQUESTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (CYL_BITS'(cylinder)),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        count_next    = count_reg;
        emitted_next  = emitted_reg;
        head_next     = head_reg;
        total_next    = total_reg;
        drop_next     = drop_reg;
        served_next   = served_reg;
        addr_next     = addr_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        last_next     = last_reg;
        rd_idx_next   = rd_idx_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_cyl_next = best_cyl_reg;
        best_d_next   = best_d_reg;
        seek_next     = seek_reg;
        seq_end_next  = seq_end_reg;

        if (cmd.load)
        begin
            if (count_reg == '0)
            begin
                head_next    = CYL_BITS'(start_head);
                total_next   = '0;
                drop_next    = 1'b0;
                served_next  = '0;
                emitted_next = '0;
            end
            if (!full)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                drop_next = 1'b1;
            end
        end

        if (cmd.scan_init)
        begin
            addr_next  = '0;
            issue_next = 1'b1;
            pend_next  = 1'b0;
            last_next  = 1'b0;
            found_next = 1'b0;
        end

        if (cmd.scan_step)
        begin
            // advance the read address; tag the beat of data due next cycle
            pend_next   = issue_reg;
            rd_idx_next = addr_reg;
            last_next   = issue_reg && addr_last;
            if (issue_reg)
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_last)
                begin
                    issue_next = 1'b0;
                end
            end
            if (pend_reg && !served_reg[rd_idx_reg])
            begin
                if (!found_reg || (seek_gap < best_d_reg))
                begin
                    found_next    = 1'b1;
                    best_idx_next = rd_idx_reg;
                    best_cyl_next = rdata;
                    best_d_next   = seek_gap;
                end
            end
        end

        if (cmd.commit)
        begin
            served_next[best_idx_reg] = 1'b1;
            head_next    = best_cyl_reg;
            total_next   = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
            seek_next    = CYL_PORT_W'(best_d_reg);
            seq_end_next = (({1'b0, emitted_reg} + 1'b1) == {1'b0, count_reg});
            emitted_next = emitted_reg + 1'b1;
        end

        if (cmd.finish)
        begin
            count_next   = '0;
            emitted_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            emitted_reg <= '0;
            head_reg    <= '0;
            total_reg   <= '0;
            drop_reg    <= 1'b0;
            served_reg  <= '0;
            addr_reg    <= '0;
            issue_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            last_reg    <= 1'b0;
            found_reg   <= 1'b0;
            seq_end_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            emitted_reg <= emitted_next;
            head_reg    <= head_next;
            total_reg   <= total_next;
            drop_reg    <= drop_next;
            served_reg  <= served_next;
            addr_reg    <= addr_next;
            issue_reg   <= issue_next;
            pend_reg    <= pend_next;
            last_reg    <= last_next;
            found_reg   <= found_next;
            seq_end_reg <= seq_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        best_cyl_reg <= best_cyl_next;
        best_d_reg   <= best_d_next;
        seek_reg     <= seek_next;
    end

    assign status.scan_done = pend_reg && last_reg;
    assign status.seq_end   = seq_end_reg;

    assign served_cylinder = CYL_PORT_W'(head_reg);
    assign seek_distance   = seek_reg;
    assign total_seek      = total_reg;
    assign overflow        = drop_reg;
    assign sequence_end    = seq_end_reg;

endmodule

### tb/sstf_order_check.sv
// ----------------------------------------------------------------------------
// sstf_order_check
// Result checker for the shortest-seek-first scheduler.
// ----------------------------------------------------------------------------
// Watches the request and result channels. Each accepted request beat that
// fits is loaded into a local copy of the batch. The beat marked batch_end
// produces the expected service order: nearest unserved cylinder first,
// earliest load on a tie, with seek distance, running total and the overflow
// flag. Each accepted result beat is compared with the oldest expected beat.
// Unexpected beats and mismatching fields are counted as failures.
// ----------------------------------------------------------------------------
module sstf_order_check
    import sstf_pkg::*;
#(
    parameter int unsigned MAX_REQUESTS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [CYL_PORT_W-1:0] cylinder,
    input  logic [CYL_PORT_W-1:0] start_head,
    input  logic                  batch_end,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [CYL_PORT_W-1:0] served_cylinder,
    input  logic [CYL_PORT_W-1:0] seek_distance,
    input  logic [TOTAL_W-1:0]    total_seek,
    input  logic                  overflow,
    input  logic                  sequence_end,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic [CYL_PORT_W-1:0] cyl;
        logic [CYL_PORT_W-1:0] seek;
        logic [TOTAL_W-1:0]    total;
        logic                  ovf;
        logic                  last;
    } seek_beat_t;

    seek_beat_t            service_q[$];
    logic [CYL_PORT_W-1:0] batch_cyl [MAX_REQUESTS];
    int unsigned           batch_cnt = 0;
    logic [CYL_PORT_W-1:0] head      = '0;
    logic                  dropped   = 1'b0;

    task automatic note_fail(input string why, input seek_beat_t want, input seek_beat_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%s: cyl %0d/%0d dist %0d/%0d total %0d/%0d ovf %0b/%0b end %0b/%0b (exp/act)",
                     why, want.cyl, got.cyl, want.seek, got.seek, want.total, got.total,
                     want.ovf, got.ovf, want.last, got.last);
    endtask

    task automatic order_batch();
        logic [MAX_REQUESTS-1:0] served;
        logic [TOTAL_W:0]        run_total;
        logic [CYL_PORT_W-1:0]   gap;
        logic [CYL_PORT_W-1:0]   best_gap;
        int unsigned             best;
        int unsigned             k;
        int unsigned             j;
        bit                      found;
        seek_beat_t              beat;
        served    = '0;
        run_total = '0;
        for (k = 0; k < batch_cnt; k++)
        begin
            found    = 1'b0;
            best     = 0;
            best_gap = '0;
            for (j = 0; j < batch_cnt; j++)
            begin
                if (!served[j])
                begin
                    gap = (batch_cyl[j] > head) ? batch_cyl[j] - head : head - batch_cyl[j];
                    if (!found || gap < best_gap)
                    begin
                        found    = 1'b1;
                        best_gap = gap;
                        best     = j;
                    end
                end
            end
            served[best] = 1'b1;
            head         = batch_cyl[best];
            run_total    = run_total + best_gap;
            if (run_total > TOTAL_MAX)
                run_total = TOTAL_MAX;
            beat.cyl   = head;
            beat.seek  = best_gap;
            beat.total = run_total[TOTAL_W-1:0];
            beat.ovf   = dropped;
            beat.last  = (k + 1 == batch_cnt);
            service_q.push_back(beat);
        end
        batch_cnt = 0;
        dropped   = 1'b0;
    endtask

    always @(posedge clk)
    begin : watch
        seek_beat_t got;
        seek_beat_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (batch_cnt == 0)
                begin
                    head    = start_head;
                    dropped = 1'b0;
                end
                if (batch_cnt < MAX_REQUESTS)
                begin
                    batch_cyl[batch_cnt] = cylinder;
                    batch_cnt++;
                end
                else
                    dropped = 1'b1;
                if (batch_end)
                    order_batch();
            end
            if (out_valid && !out_stall)
            begin
                got = '{served_cylinder, seek_distance, total_seek, overflow, sequence_end};
                if (service_q.size() == 0)
                    note_fail("unexpected result beat", '0, got);
                else
                begin
                    want = service_q.pop_front();
                    if (want != got)
                        note_fail("result mismatch", want, got);
                end
            end
            pending = service_q.size();
        end
    end

endmodule

### tb/tb_shortest_seek_first_scheduler_unit.sv
// ----------------------------------------------------------------------------
// tb_shortest_seek_first_scheduler_unit
// Testbench top for the shortest-seek-first scheduler.
// ----------------------------------------------------------------------------
// Sends a few directed batches (extreme cylinders, equal-distance ties,
// duplicates, head reload), then random batches: mostly short ones with
// spread, clustered or extreme cylinders, plus a full batch and batches that
// overflow the request store. The sender idles in bursts, the receiver stalls
// on its own pattern and once holds off long enough to back up the input.
// Checking is done by sstf_order_check beside the block.
// ----------------------------------------------------------------------------
module tb_shortest_seek_first_scheduler_unit;
    import sstf_pkg::*;

    localparam int unsigned MAX_REQ = 64;

    typedef enum int {
        FILL_SPREAD,
        FILL_CLUSTER,
        FILL_EDGES
    } fill_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [CYL_PORT_W-1:0] cylinder;
    logic [CYL_PORT_W-1:0] start_head;
    logic                  batch_end;
    logic                  out_valid;
    logic                  out_stall;
    logic [CYL_PORT_W-1:0] served_cylinder;
    logic [CYL_PORT_W-1:0] seek_distance;
    logic [TOTAL_W-1:0]    total_seek;
    logic                  overflow;
    logic                  sequence_end;
    int                    fail_count;
    int                    pending;

    int burst_left   = 0;
    int requests_put = 0;

    shortest_seek_first_scheduler_unit #(
        .MAX_REQUESTS (MAX_REQ),
        .CYL_BITS     (16)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cylinder        (cylinder),
        .start_head      (start_head),
        .batch_end       (batch_end),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .served_cylinder (served_cylinder),
        .seek_distance   (seek_distance),
        .total_seek      (total_seek),
        .overflow        (overflow),
        .sequence_end    (sequence_end)
    );

    sstf_order_check #(
        .MAX_REQUESTS (MAX_REQ)
    ) order_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cylinder        (cylinder),
        .start_head      (start_head),
        .batch_end       (batch_end),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .served_cylinder (served_cylinder),
        .seek_distance   (seek_distance),
        .total_seek      (total_seek),
        .overflow        (overflow),
        .sequence_end    (sequence_end),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("shortest_seek_first_scheduler_unit test failed");
        $finish;
    end

    task automatic send_request(input logic [CYL_PORT_W-1:0] cyl,
                                input logic [CYL_PORT_W-1:0] head,
                                input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid   <= 1'b1;
        cylinder   <= cyl;
        start_head <= head;
        batch_end  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        requests_put++;
    endtask

    function automatic logic [CYL_PORT_W-1:0] pick_cylinder(input fill_mode_t mode,
                                                            input logic [CYL_PORT_W-1:0] base);
        case (mode)
            FILL_CLUSTER: return base + CYL_PORT_W'($urandom_range(0, 7));
            FILL_EDGES:
            begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    default: return CYL_PORT_W'($urandom);
                endcase
            end
            default:      return CYL_PORT_W'($urandom);
        endcase
    endfunction

    task automatic run_batch(input int size);
        fill_mode_t            mode;
        logic [CYL_PORT_W-1:0] base;
        logic [CYL_PORT_W-1:0] first_head;
        int                    i;
        mode       = fill_mode_t'($urandom_range(0, 2));
        base       = CYL_PORT_W'($urandom);
        first_head = pick_cylinder(mode, base);
        for (i = 0; i < size; i++)
            send_request(pick_cylinder(mode, base),
                         (i == 0) ? first_head : CYL_PORT_W'($urandom),
                         i == size - 1);
    endtask

    initial
    begin : receiver
        int run_left;
        int hold_left;
        int beats_taken;
        bit run_stall;
        bit held;
        run_left    = 0;
        hold_left   = 0;
        beats_taken = 0;
        run_stall   = 1'b0;
        held        = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                beats_taken++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!held && beats_taken >= 40)
            begin
                held      = 1'b1;
                hold_left = 300;
                out_stall <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        run_stall = 1'b0;
                        run_left  = $urandom_range(20, 60);
                    end
                    else
                    begin
                        run_stall = !run_stall;
                        run_left  = run_stall ? $urandom_range(1, 4) : $urandom_range(1, 6);
                    end
                end
                run_left--;
                out_stall <= run_stall;
            end
        end
    end

    initial
    begin : stimulus
        int b;
        int size;
        int random_start;
        in_valid   <= 1'b0;
        cylinder   <= '0;
        start_head <= '0;
        batch_end  <= 1'b0;
        rst_n      <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(16'd0, 16'hFFFF, 1'b1);
        send_request(16'hFFFF, 16'd0, 1'b1);
        // equal distance from the head: earliest load wins
        send_request(16'd110, 16'd100, 1'b0);
        send_request(16'd90, 16'd7, 1'b0);
        send_request(16'd100, 16'd0, 1'b1);
        send_request(16'd7, 16'd5, 1'b0);
        send_request(16'd7, 16'hFFFF, 1'b0);
        send_request(16'd3, 16'd1234, 1'b1);
        send_request(16'd0, 16'h8000, 1'b0);
        send_request(16'hFFFF, 16'h0001, 1'b0);
        send_request(16'h8000, 16'hFFFF, 1'b0);
        send_request(16'h0001, 16'h0000, 1'b0);
        send_request(16'hFFFE, 16'h5555, 1'b1);
        send_request(16'h5555, 16'hAAAA, 1'b0);
        send_request(16'hAAAA, 16'h5555, 1'b1);
        // head reloads from start_head, not the last served cylinder
        send_request(16'd0, 16'd0, 1'b1);
        send_request(16'hFFFF, 16'd0, 1'b0);
        send_request(16'd0, 16'hFFFF, 1'b0);
        send_request(16'hFFFF, 16'h1234, 1'b0);
        send_request(16'd0, 16'h4321, 1'b1);

        random_start = requests_put;
        b = 0;
        while (requests_put - random_start < 370)
        begin
            if (b == 2)
                size = MAX_REQ;
            else if (b == 6)
                size = MAX_REQ + 1;
            else if (b == 11)
                size = $urandom_range(MAX_REQ + 2, MAX_REQ + 6);
            else if ($urandom_range(0, 9) < 7)
                size = $urandom_range(1, 8);
            else
                size = $urandom_range(9, 24);
            run_batch(size);
            b++;
            if (b == 8)
            begin
                in_valid <= 1'b0;
                do @(negedge clk); while (pending != 0);
                @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        do @(negedge clk); while (pending != 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("shortest_seek_first_scheduler_unit test passed");
        else
            $display("shortest_seek_first_scheduler_unit test failed");
        $finish;
    end

endmodule

### shortest_seek_first_scheduler_unit.f
sv/sstf_pkg.sv
sv/sstf_ram.sv
sv/sstf_ctrl.sv
sv/sstf_dp.sv
sv/shortest_seek_first_scheduler_unit.sv
tb/sstf_order_check.sv
tb/tb_shortest_seek_first_scheduler_unit.sv
